FILE: src/heightmap_height_query_core_macros.svh
// assertion macros for the height query core
`ifndef HEIGHTMAP_HEIGHT_QUERY_CORE_MACROS_SVH
`define HEIGHTMAP_HEIGHT_QUERY_CORE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define HHQ_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define HHQ_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define HHQ_ASSERT_IMP(name, ante, cons, msg)
`define HHQ_ASSERT_NEXT(name, ante, cons, msg)
`endif
`endif

FILE: src/hhq_pkg.sv
// shared types, constants and helpers of the height query core
package hhq_pkg;

	// grid size limits
	localparam int MAX_COLUMNS = 64;
	localparam int MAX_ROWS    = 64;
	localparam int MAX_DIM     = (MAX_COLUMNS > MAX_ROWS) ? MAX_COLUMNS : MAX_ROWS;
	localparam int QW          = $clog2(MAX_DIM);

	// field widths
	localparam int DIM_W      = 7;
	localparam int CMP_W      = (QW > DIM_W) ? QW : DIM_W;
	localparam int IDX_W      = 12;
	localparam int STORE_DEPTH = 4096;
	localparam int SAMPLE_W   = 16;
	localparam int POS_W      = 32;
	localparam int DELTA_W    = POS_W + 1;
	localparam int REM_W      = 32;
	localparam int ST_W       = 31;
	localparam int LIM_W      = ST_W + DIM_W;
	localparam int CW         = ST_W + QW;
	localparam int AD_W       = QW + DIM_W + 1;
	localparam int H_W        = 24;

	// interpolation arithmetic
	localparam int WT_W   = ST_W + 1;
	localparam int DIFF_W = SAMPLE_W + 1;
	localparam int PROD_W = WT_W + DIFF_W;
	localparam int QB     = 26;
	localparam int BIAS_SH = QB - 1;
	localparam int Q_BIAS = 1 << (QB - 2);
	localparam int NUM_SH = 9;
	localparam int ND_W   = 57;
	localparam int ND_X_W = ND_W + 1;
	localparam int DV_W   = ST_W + 1;
	localparam int HX_W   = H_W + 3;
	localparam logic signed [HX_W-1:0] HX_MAX = HX_W'((1 << (H_W - 1)) - 1);
	localparam logic signed [HX_W-1:0] HX_MIN = HX_W'(-(1 << (H_W - 1)));

	// queue between front and back
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_COLUMNS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STRIDE       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_START_X      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_START_Y      = 3'd4;

	// operation codes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// reset values of the derived configuration
	localparam logic [ST_W-1:0] STRIDE_RESET = ST_W'(65536);
	localparam logic [DIM_W-1:0] DIM_RESET   = DIM_W'(2);
	localparam logic [ND_W-1:0] ST_K_RESET   =
		(ND_W'(STRIDE_RESET) << BIAS_SH) + ND_W'(STRIDE_RESET);

	// configuration as seen by the datapath
	typedef struct packed {
		logic [DIM_W-1:0] cols;
		logic [DIM_W-1:0] rows;
		logic [ST_W-1:0]  st;
		logic [LIM_W-1:0] lim_x;
		logic [LIM_W-1:0] lim_y;
		logic [ND_W-1:0]  st_k;
		logic [POS_W-1:0] start_x;
		logic [POS_W-1:0] start_y;
	} cfg_t;

	// classified item handed from front to back
	typedef struct packed {
		logic                op;
		logic [IDX_W-1:0]    idx;
		logic [SAMPLE_W-1:0] sample;
		logic                outside;
		logic [QW-1:0]       c;
		logic [QW-1:0]       r;
		logic [ST_W-1:0]     rx;
		logic [ST_W-1:0]     ry;
	} fq_t;

	// queue status
	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	// saturate a grid dimension to [2, mx]
	function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v, int mx);
		logic [DIM_W-1:0] r;
		r = v;
		if (v < DIM_W'(2)) begin
			r = DIM_W'(2);
		end else if (int'(v) > mx) begin
			r = DIM_W'(mx);
		end
		return r;
	endfunction

endpackage

FILE: src/hhq_ram.sv
// generic single write port ram with registered read
module hhq_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: src/hhq_front.sv
// front end: offsets, bounds check and pipelined cell division
module hhq_front import hhq_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cfg_t                       cfg,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       operation,
	input  logic [IDX_W-1:0]           cell_index,
	input  logic signed [SAMPLE_W-1:0] height_sample,
	input  logic signed [POS_W-1:0]    pos_x,
	input  logic signed [POS_W-1:0]    pos_y,
	output logic                       push,
	output fq_t                        push_item,
	input  logic                       fifo_ready
);

	typedef struct packed {
		logic                op;
		logic [IDX_W-1:0]    idx;
		logic [SAMPLE_W-1:0] sample;
		logic                outside;
		logic [REM_W-1:0]    rem_x;
		logic [REM_W-1:0]    rem_y;
		logic [QW-1:0]       q_x;
		logic [QW-1:0]       q_y;
	} fdiv_t;

	// one restoring step on both axes for quotient bit k
	function automatic fdiv_t div_step(fdiv_t d, logic [ST_W-1:0] st, int k);
		logic [CW-1:0] sh;
		sh = CW'(st) << k;
		if (CW'(d.rem_x) >= sh) begin
			d.rem_x  = d.rem_x - REM_W'(sh);
			d.q_x[k] = 1'b1;
		end
		if (CW'(d.rem_y) >= sh) begin
			d.rem_y  = d.rem_y - REM_W'(sh);
			d.q_y[k] = 1'b1;
		end
		return d;
	endfunction

	logic                       fe;
	logic                       vld_s1;
	logic                       op_s1;
	logic [IDX_W-1:0]           idx_s1;
	logic [SAMPLE_W-1:0]        sample_s1;
	logic signed [DELTA_W-1:0]  dx_s1;
	logic signed [DELTA_W-1:0]  dy_s1;
	logic                       vld_s2;
	fdiv_t                      st_s2;
	fdiv_t                      st_d;
	logic                       div_vld_s3 [QW];
	fdiv_t                      div_s3 [QW];
	fdiv_t                      div_d [QW];
	fdiv_t                      last;
	logic [CMP_W-1:0]           cmax_x;
	logic [CMP_W-1:0]           cmax_y;

	// whole front advances unless its tail cannot move into the queue
	assign fe       = !div_vld_s3[QW-1] || fifo_ready;
	assign in_ready = fe;

	// stage 1: offsets from the grid origin
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (fe) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (fe) begin
			op_s1     <= operation;
			idx_s1    <= cell_index;
			sample_s1 <= height_sample;
			dx_s1     <= DELTA_W'(pos_x) - DELTA_W'($signed(cfg.start_x));
			dy_s1     <= DELTA_W'(pos_y) - DELTA_W'($signed(cfg.start_y));
		end
	end

	// stage 2: bounds check, divider load
	always_comb begin
		st_d         = '0;
		st_d.op      = op_s1;
		st_d.idx     = idx_s1;
		st_d.sample  = sample_s1;
		st_d.outside = dx_s1[DELTA_W-1] || dy_s1[DELTA_W-1]
			|| (dx_s1 > $signed({1'b0, cfg.lim_x}))
			|| (dy_s1 > $signed({1'b0, cfg.lim_y}));
		st_d.rem_x   = dx_s1[REM_W-1:0];
		st_d.rem_y   = dy_s1[REM_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (fe) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fe) begin
			st_s2 <= st_d;
		end
	end

	// divider steps, one quotient bit per stage
	always_comb begin
		div_d[0] = div_step(st_s2, cfg.st, QW - 1);
		for (int j = 1; j < QW; j++) begin
			div_d[j] = div_step(div_s3[j-1], cfg.st, QW - 1 - j);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < QW; j++) begin
				div_vld_s3[j] <= 1'b0;
			end
		end else if (fe) begin
			div_vld_s3[0] <= vld_s2;
			for (int j = 1; j < QW; j++) begin
				div_vld_s3[j] <= div_vld_s3[j-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fe) begin
			for (int j = 0; j < QW; j++) begin
				div_s3[j] <= div_d[j];
			end
		end
	end

	// tail: clamp to the last cell and hand over to the queue
	assign last   = div_s3[QW-1];
	assign cmax_x = CMP_W'(cfg.cols) - CMP_W'(2);
	assign cmax_y = CMP_W'(cfg.rows) - CMP_W'(2);

	always_comb begin
		push_item         = '0;
		push_item.op      = last.op;
		push_item.idx     = last.idx;
		push_item.sample  = last.sample;
		push_item.outside = last.outside;
		if (CMP_W'(last.q_x) > cmax_x) begin
			push_item.c  = QW'(cmax_x);
			push_item.rx = cfg.st;
		end else begin
			push_item.c  = last.q_x;
			push_item.rx = ST_W'(last.rem_x);
		end
		if (CMP_W'(last.q_y) > cmax_y) begin
			push_item.r  = QW'(cmax_y);
			push_item.ry = cfg.st;
		end else begin
			push_item.r  = last.q_y;
			push_item.ry = ST_W'(last.rem_y);
		end
	end

	assign push = div_vld_s3[QW-1] && fifo_ready;

endmodule

FILE: src/hhq_fifo.sv
// short queue between front and back
module hhq_fifo import hhq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  fq_t        push_item,
	input  logic       pop,
	output fq_t        head,
	output fifo_stat_t stat
);

	fq_t                mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_AW:0]   cnt_q;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (FIFO_AW+1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (FIFO_AW+1)'(1);
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	assign head       = mem_q[rd_ptr_q];
	assign stat.full  = (cnt_q == (FIFO_AW+1)'(FIFO_DEPTH));
	assign stat.empty = (cnt_q == '0);

endmodule

FILE: src/hhq_back.sv
// back end: corner reads, planar interpolation and rounding division
module hhq_back import hhq_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cfg_t                     cfg,
	input  fq_t                      head,
	input  fifo_stat_t               stat,
	output logic                     pop,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [H_W-1:0]    height_out,
	output logic                     outside
);

	typedef struct packed {
		logic                outside;
		logic [SAMPLE_W-1:0] z0;
		logic [ND_W-1:0]     rem;
		logic [QB-1:0]       q;
	} bdiv_t;

	// one restoring step of the rounding division for quotient bit k
	function automatic bdiv_t div_step(bdiv_t d, logic [DV_W-1:0] dv, int k);
		logic [ND_W-1:0] sh;
		sh = ND_W'(dv) << k;
		if (d.rem >= sh) begin
			d.rem  = d.rem - sh;
			d.q[k] = 1'b1;
		end
		return d;
	endfunction

	logic                       be;
	logic                       vld_s1;
	fq_t                        it_s1;
	logic [IDX_W-1:0]           a_ul;
	logic [IDX_W-1:0]           a_ur;
	logic [IDX_W-1:0]           a_bl;
	logic [IDX_W-1:0]           a_br;
	logic                       far_tri;
	logic [ST_W-1:0]            w1;
	logic [ST_W-1:0]            w2;
	logic                       ram_we;
	logic [SAMPLE_W-1:0]        z1;
	logic [SAMPLE_W-1:0]        z2;
	logic [SAMPLE_W-1:0]        z0;
	logic                       vld_s2;
	logic                       outside_s2;
	logic [ST_W-1:0]            w1_s2;
	logic [ST_W-1:0]            w2_s2;
	logic                       vld_s3;
	logic                       outside_s3;
	logic [SAMPLE_W-1:0]        z0_s3;
	logic signed [DIFF_W-1:0]   d1_s3;
	logic signed [DIFF_W-1:0]   d2_s3;
	logic [ST_W-1:0]            w1_s3;
	logic [ST_W-1:0]            w2_s3;
	logic                       vld_s4;
	logic                       outside_s4;
	logic [SAMPLE_W-1:0]        z0_s4;
	logic signed [PROD_W-1:0]   p1_s4;
	logic signed [PROD_W-1:0]   p2_s4;
	logic signed [ND_X_W-1:0]   nsum;
	logic                       vld_s5;
	bdiv_t                      nd_s5;
	logic                       div_vld_s6 [QB];
	bdiv_t                      div_s6 [QB];
	bdiv_t                      div_d [QB];
	bdiv_t                      last;
	logic signed [HX_W-1:0]     hsum;
	logic signed [H_W-1:0]      h_d;
	logic                       out_valid_q;
	logic signed [H_W-1:0]      height_q;
	logic                       outside_q;

	// whole back advances unless the output register is held
	assign be  = !out_valid_q || out_ready;
	assign pop = be && !stat.empty;

	// stage 1: item taken from the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (be) begin
			vld_s1 <= !stat.empty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			it_s1 <= head;
		end
	end

	// corner addresses, triangle choice and weights
	always_comb begin
		a_ul = IDX_W'(AD_W'(it_s1.r) * AD_W'(cfg.cols) + AD_W'(it_s1.c));
		a_ur = a_ul + IDX_W'(1);
		a_bl = a_ul + IDX_W'(cfg.cols);
		a_br = a_bl + IDX_W'(1);
		far_tri = ({1'b0, it_s1.rx} + {1'b0, it_s1.ry}) > {1'b0, cfg.st};
		if (far_tri) begin
			w1 = cfg.st - it_s1.ry;
			w2 = cfg.st - it_s1.rx;
		end else begin
			w1 = it_s1.rx;
			w2 = it_s1.ry;
		end
	end

	// sample writes land here, in item order with the reads
	assign ram_we = vld_s1 && be && (it_s1.op == OP_WRITE);

	// three copies of the store, one per corner read
	hhq_ram #(.WIDTH(SAMPLE_W), .DEPTH(STORE_DEPTH)) u_ram_ur (
		.clk   (clk),
		.we    (ram_we),
		.waddr (it_s1.idx),
		.wdata (it_s1.sample),
		.re    (be),
		.raddr (a_ur),
		.rdata (z1)
	);

	hhq_ram #(.WIDTH(SAMPLE_W), .DEPTH(STORE_DEPTH)) u_ram_bl (
		.clk   (clk),
		.we    (ram_we),
		.waddr (it_s1.idx),
		.wdata (it_s1.sample),
		.re    (be),
		.raddr (a_bl),
		.rdata (z2)
	);

	hhq_ram #(.WIDTH(SAMPLE_W), .DEPTH(STORE_DEPTH)) u_ram_pivot (
		.clk   (clk),
		.we    (ram_we),
		.waddr (it_s1.idx),
		.wdata (it_s1.sample),
		.re    (be),
		.raddr (far_tri ? a_br : a_ul),
		.rdata (z0)
	);

	// stage 2: wait for read data, writes leave the pipe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (be) begin
			vld_s2 <= vld_s1 && (it_s1.op == OP_QUERY);
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	// stage 5 numerator with bias so the division is unsigned
	assign nsum = ((ND_X_W'(p1_s4) + ND_X_W'(p2_s4)) <<< NUM_SH)
		+ $signed({1'b0, cfg.st_k});

	// stages 2 to 5: differences, products, numerator
	always_ff @(posedge clk) begin
		if (be) begin
			outside_s2 <= it_s1.outside;
			w1_s2      <= w1;
			w2_s2      <= w2;

			outside_s3 <= outside_s2;
			z0_s3      <= z0;
			d1_s3      <= DIFF_W'($signed(z1)) - DIFF_W'($signed(z0));
			d2_s3      <= DIFF_W'($signed(z2)) - DIFF_W'($signed(z0));
			w1_s3      <= w1_s2;
			w2_s3      <= w2_s2;

			outside_s4 <= outside_s3;
			z0_s4      <= z0_s3;
			p1_s4      <= $signed({1'b0, w1_s3}) * d1_s3;
			p2_s4      <= $signed({1'b0, w2_s3}) * d2_s3;

			nd_s5.outside <= outside_s4;
			nd_s5.z0      <= z0_s4;
			nd_s5.rem     <= nsum[ND_W-1:0];
			nd_s5.q       <= '0;
		end
	end

	// rounding division by twice the stride, one bit per stage
	always_comb begin
		div_d[0] = div_step(nd_s5, {cfg.st, 1'b0}, QB - 1);
		for (int j = 1; j < QB; j++) begin
			div_d[j] = div_step(div_s6[j-1], {cfg.st, 1'b0}, QB - 1 - j);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < QB; j++) begin
				div_vld_s6[j] <= 1'b0;
			end
		end else if (be) begin
			div_vld_s6[0] <= vld_s5;
			for (int j = 1; j < QB; j++) begin
				div_vld_s6[j] <= div_vld_s6[j-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (be) begin
			for (int j = 0; j < QB; j++) begin
				div_s6[j] <= div_d[j];
			end
		end
	end

	// remove bias, add base sample, saturate
	assign last = div_s6[QB-1];
	assign hsum = (HX_W'($signed(last.z0)) <<< 8) + $signed(HX_W'(last.q))
		- $signed(HX_W'(Q_BIAS));

	always_comb begin
		if (last.outside) begin
			h_d = '0;
		end else if (hsum > HX_MAX) begin
			h_d = HX_MAX[H_W-1:0];
		end else if (hsum < HX_MIN) begin
			h_d = HX_MIN[H_W-1:0];
		end else begin
			h_d = hsum[H_W-1:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (be) begin
			out_valid_q <= div_vld_s6[QB-1];
		end
	end

	always_ff @(posedge clk) begin
		if (be) begin
			height_q  <= h_d;
			outside_q <= last.outside;
		end
	end

	assign out_valid  = out_valid_q;
	assign height_out = height_q;
	assign outside    = outside_q;

endmodule

FILE: src/heightmap_height_query_core.sv
// top level of the heightmap height query core
//
// Input channel (in_valid/in_ready) takes one item per transfer: operation 0
// stores height_sample at cell_index, operation 1 queries the height at
// (pos_x, pos_y) in Q16.16. Each query gives one result on the output channel
// (out_valid/out_ready): height_out with 8 fraction bits, or outside set and
// height_out zero. Writes give no result and take effect in order with queries.
// Throughput is one item per cycle unless the queue or the output stalls.
// A query with 64 row and column limits passes through offsets and bounds
// check, a 6-stage cell divider, the queue, corner reads, products and a
// 26-stage rounding divider by twice the stride, one quotient bit per stage.
// The store is three copies of a 4096-entry ram so the three corners of a
// triangle are read in the same cycle; it is not cleared and must be written
// before it is read. Reset empties the pipeline and queue and loads the
// register defaults. A stalled receiver holds the output register and the
// back end; the front keeps accepting until the 4-entry queue fills.
// Configuration writes through cfg_we/cfg_index/cfg_data belong to idle
// periods.
`include "heightmap_height_query_core_macros.svh"
module heightmap_height_query_core import hhq_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       operation,
	input  logic [IDX_W-1:0]           cell_index,
	input  logic signed [SAMPLE_W-1:0] height_sample,
	input  logic signed [POS_W-1:0]    pos_x,
	input  logic signed [POS_W-1:0]    pos_y,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [H_W-1:0]      height_out,
	output logic                       outside
);

	logic [DIM_W-1:0] cfg_cols_q;
	logic [DIM_W-1:0] cfg_rows_q;
	logic [ST_W-1:0]  cfg_stride_q;
	logic [POS_W-1:0] cfg_start_x_q;
	logic [POS_W-1:0] cfg_start_y_q;
	cfg_t             cfg_d;
	cfg_t             cfg_q;
	cfg_t             cfg_front;
	logic             push;
	fq_t              push_item;
	logic             pop;
	fq_t              head;
	fifo_stat_t       fifo_stat;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_cols_q    <= DIM_RESET;
			cfg_rows_q    <= DIM_RESET;
			cfg_stride_q  <= STRIDE_RESET;
			cfg_start_x_q <= '0;
			cfg_start_y_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GRID_COLUMNS: cfg_cols_q    <= cfg_data[DIM_W-1:0];
				REG_GRID_ROWS:    cfg_rows_q    <= cfg_data[DIM_W-1:0];
				REG_STRIDE:       cfg_stride_q  <= cfg_data[ST_W-1:0];
				REG_START_X:      cfg_start_x_q <= cfg_data[POS_W-1:0];
				REG_START_Y:      cfg_start_y_q <= cfg_data[POS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// derived configuration: saturated sizes, nonzero stride, grid extent, numerator bias
	always_comb begin
		cfg_d.cols    = clamp_dim(cfg_cols_q, MAX_COLUMNS);
		cfg_d.rows    = clamp_dim(cfg_rows_q, MAX_ROWS);
		cfg_d.st      = (cfg_stride_q == '0) ? ST_W'(1) : cfg_stride_q;
		cfg_d.lim_x   = LIM_W'(cfg_d.st) * LIM_W'(cfg_d.cols - DIM_W'(1));
		cfg_d.lim_y   = LIM_W'(cfg_d.st) * LIM_W'(cfg_d.rows - DIM_W'(1));
		cfg_d.st_k    = (ND_W'(cfg_d.st) << BIAS_SH) + ND_W'(cfg_d.st);
		cfg_d.start_x = cfg_start_x_q;
		cfg_d.start_y = cfg_start_y_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cols    <= DIM_RESET;
			cfg_q.rows    <= DIM_RESET;
			cfg_q.st      <= STRIDE_RESET;
			cfg_q.lim_x   <= LIM_W'(STRIDE_RESET);
			cfg_q.lim_y   <= LIM_W'(STRIDE_RESET);
			cfg_q.st_k    <= ST_K_RESET;
			cfg_q.start_x <= '0;
			cfg_q.start_y <= '0;
		end else begin
			cfg_q <= cfg_d;
		end
	end

	// first front stage takes the origin straight from the registers
	always_comb begin
		cfg_front         = cfg_q;
		cfg_front.start_x = cfg_start_x_q;
		cfg_front.start_y = cfg_start_y_q;
	end

	hhq_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_front),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.operation     (operation),
		.cell_index    (cell_index),
		.height_sample (height_sample),
		.pos_x         (pos_x),
		.pos_y         (pos_y),
		.push          (push),
		.push_item     (push_item),
		.fifo_ready    (!fifo_stat.full)
	);

	hhq_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.stat      (fifo_stat)
	);

	hhq_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head       (head),
		.stat       (fifo_stat),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.height_out (height_out),
		.outside    (outside)
	);

	// checks
	`HHQ_ASSERT_IMP(a_stall_only_on_full_queue, !in_ready, fifo_stat.full, "input stalled with queue room")
	`HHQ_ASSERT_IMP(a_outside_reads_zero, out_valid && outside, height_out == '0, "outside result not zero")
	`HHQ_ASSERT_NEXT(a_cols_written, cfg_we && (cfg_index == REG_GRID_COLUMNS), cfg_cols_q == $past(cfg_data[DIM_W-1:0]), "column register not written")

endmodule

FILE: tb/sv/heightmap_height_query_core_test.sv
// self-checking testbench for the heightmap height query core
`timescale 1ns / 100ps
module heightmap_height_query_core_test;
	import hhq_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 60;
	localparam int HOLD_CYCLES    = 300;
	localparam int ITEMS_PER_SET  = 70;
	localparam int NUM_SETS       = 8;
	localparam int REPORT_LIMIT   = 10;

	// one result of a height query
	typedef struct {
		logic signed [H_W-1:0] height;
		logic                  off_grid;
	} height_res_t;

	// one row of the directed table
	typedef struct {
		logic                       op;
		logic [IDX_W-1:0]           idx;
		logic signed [SAMPLE_W-1:0] sample;
		logic signed [POS_W-1:0]    px;
		logic signed [POS_W-1:0]    py;
		bit                         typed;
		logic signed [H_W-1:0]      height;
		logic                       off_grid;
	} directed_row_t;

	// one grid setting
	typedef struct {
		logic [31:0] cols;
		logic [31:0] rows;
		logic [31:0] stride;
		logic [31:0] sx;
		logic [31:0] sy;
	} grid_set_t;

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_we;
	logic [CFG_IDX_W-1:0]       cfg_index;
	logic [CFG_DATA_W-1:0]      cfg_data;
	logic                       in_valid;
	logic                       in_ready;
	logic                       operation;
	logic [IDX_W-1:0]           cell_index;
	logic signed [SAMPLE_W-1:0] height_sample;
	logic signed [POS_W-1:0]    pos_x;
	logic signed [POS_W-1:0]    pos_y;
	logic                       out_valid;
	logic                       out_ready;
	logic signed [H_W-1:0]      height_out;
	logic                       outside;

	// predictor copy of the registers and the sample store
	logic [DIM_W-1:0]           grid_cols;
	logic [DIM_W-1:0]           grid_rows;
	logic [ST_W-1:0]            grid_stride;
	logic signed [POS_W-1:0]    grid_start_x;
	logic signed [POS_W-1:0]    grid_start_y;
	logic signed [SAMPLE_W-1:0] sample_mem [STORE_DEPTH];

	height_res_t pending_heights[$];
	int  fail_count;
	int  mismatch_count;
	int  query_count;
	int  write_count;
	int  outside_count;
	int  idle_in_pct;
	int  stall_out_pct;
	int  hold_requests;
	int  hold_served;
	int  hold_left;
	int  quiet_cycles;
	int  filled_to;

	heightmap_height_query_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.operation(operation), .cell_index(cell_index), .height_sample(height_sample),
		.pos_x(pos_x), .pos_y(pos_y),
		.out_valid(out_valid), .out_ready(out_ready),
		.height_out(height_out), .outside(outside)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// planar interpolation over the triangle that holds the position
	function automatic height_res_t interpolate_height(logic signed [POS_W-1:0] px,
			logic signed [POS_W-1:0] py);
		height_res_t res;
		longint cols, rows, st, dx, dy, c, r, rx, ry, z0, z1, z2, n, num, den, q, h;
		cols = (grid_cols < 2) ? 2 : ((grid_cols > MAX_COLUMNS) ? MAX_COLUMNS : grid_cols);
		rows = (grid_rows < 2) ? 2 : ((grid_rows > MAX_ROWS) ? MAX_ROWS : grid_rows);
		st = (grid_stride == 0) ? 1 : longint'(grid_stride);
		dx = longint'(px) - longint'(grid_start_x);
		dy = longint'(py) - longint'(grid_start_y);
		res.height = '0;
		res.off_grid = 1'b1;
		if (dx < 0 || dy < 0 || dx > st * (cols - 1) || dy > st * (rows - 1))
			return res;
		c = dx / st;
		if (c > cols - 2)
			c = cols - 2;
		r = dy / st;
		if (r > rows - 2)
			r = rows - 2;
		rx = dx - c * st;
		ry = dy - r * st;
		z1 = sample_mem[(r * cols + c + 1) & (STORE_DEPTH - 1)];
		z2 = sample_mem[((r + 1) * cols + c) & (STORE_DEPTH - 1)];
		if (rx + ry > st) begin
			z0 = sample_mem[((r + 1) * cols + c + 1) & (STORE_DEPTH - 1)];
			n = (st - ry) * (z1 - z0) + (st - rx) * (z2 - z0);
		end else begin
			z0 = sample_mem[(r * cols + c) & (STORE_DEPTH - 1)];
			n = rx * (z1 - z0) + ry * (z2 - z0);
		end
		// round half up: floor((2n*256 + st) / 2st)
		num = 2 * n * 256 + st;
		den = 2 * st;
		q = num / den;
		if ((num % den) != 0 && num < 0)
			q--;
		h = z0 * 256 + q;
		if (h > 8388607)
			h = 8388607;
		if (h < -8388608)
			h = -8388608;
		res.height = h[H_W-1:0];
		res.off_grid = 1'b0;
		return res;
	endfunction

	// register write, mirrored in the predictor
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			REG_GRID_COLUMNS: grid_cols = data[DIM_W-1:0];
			REG_GRID_ROWS:    grid_rows = data[DIM_W-1:0];
			REG_STRIDE:       grid_stride = data[ST_W-1:0];
			REG_START_X:      grid_start_x = data;
			REG_START_Y:      grid_start_y = data;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// offer one item and wait for its transfer; valid is left high
	task automatic send_item(logic op, logic [IDX_W-1:0] idx, logic [SAMPLE_W-1:0] sample,
			logic [POS_W-1:0] px, logic [POS_W-1:0] py, bit typed, height_res_t typed_res);
		height_res_t res;
		if (idle_in_pct > 0 && $urandom_range(99) < idle_in_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		cell_index <= idx;
		height_sample <= sample;
		pos_x <= px;
		pos_y <= py;
		do @(posedge clk); while (!in_ready);
		if (op == OP_WRITE) begin
			sample_mem[idx] = sample;
			write_count++;
		end else begin
			res = typed ? typed_res : interpolate_height(px, py);
			pending_heights.push_back(res);
			query_count++;
			if (res.off_grid)
				outside_count++;
		end
	endtask

	// write every sample the current grid can read that is still unwritten
	task automatic fill_grid();
		height_res_t blank;
		int cols;
		int rows;
		blank.height = '0;
		blank.off_grid = 1'b0;
		cols = (grid_cols < 2) ? 2 : ((grid_cols > MAX_COLUMNS) ? MAX_COLUMNS : grid_cols);
		rows = (grid_rows < 2) ? 2 : ((grid_rows > MAX_ROWS) ? MAX_ROWS : grid_rows);
		while (filled_to < cols * rows) begin
			send_item(OP_WRITE, IDX_W'(filled_to), SAMPLE_W'($urandom), '0, '0, 1'b0, blank);
			filled_to++;
		end
	endtask

	// lower valid and let the pipeline empty before a register write
	task automatic drain_pipe();
		in_valid <= 1'b0;
		wait (pending_heights.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// random query position, mostly on or near the grid
	task automatic pick_position(output logic [POS_W-1:0] px, output logic [POS_W-1:0] py);
		longint st, span_x, span_y, dx, dy;
		int mode;
		st = (grid_stride == 0) ? 1 : longint'(grid_stride);
		span_x = st * (((grid_cols < 2) ? 2 : ((grid_cols > 64) ? 64 : grid_cols)) - 1);
		span_y = st * (((grid_rows < 2) ? 2 : ((grid_rows > 64) ? 64 : grid_rows)) - 1);
		mode = $urandom_range(99);
		if (mode < 60) begin
			dx = longint'({$urandom, $urandom} % (span_x + 1));
			dy = longint'({$urandom, $urandom} % (span_y + 1));
		end else if (mode < 75) begin
			dx = st * longint'($urandom_range(0, 64)) % (span_x + 1);
			dy = st * longint'($urandom_range(0, 64)) % (span_y + 1);
		end else if (mode < 90) begin
			case ($urandom_range(3))
				0: dx = -1;
				1: dx = span_x + 1;
				2: dx = 0;
				default: dx = span_x;
			endcase
			dy = ($urandom_range(1)) ? span_y : longint'($urandom) % (span_y + 1);
		end else begin
			px = $urandom;
			py = $urandom;
			return;
		end
		px = POS_W'(longint'(grid_start_x) + dx);
		py = POS_W'(longint'(grid_start_y) + dy);
	endtask

	// receiver: random stalls and the long hold-off
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_served != hold_requests) begin
			hold_served <= hold_served + 1;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= stall_out_pct);
		end
	end

	// result check against the oldest expected height
	always @(posedge clk) begin
		height_res_t exp_res;
		if (arst_n && out_valid && out_ready) begin
			if (pending_heights.size() == 0) begin
				fail_count++;
				if (mismatch_count < REPORT_LIMIT)
					$display("unexpected result: height %0d outside %0b", height_out, outside);
				mismatch_count++;
			end else begin
				exp_res = pending_heights.pop_front();
				if (height_out !== exp_res.height || outside !== exp_res.off_grid) begin
					fail_count++;
					if (mismatch_count < REPORT_LIMIT)
						$display("mismatch: expected height %0d outside %0b, got %0d %0b",
							exp_res.height, exp_res.off_grid, height_out, outside);
					mismatch_count++;
				end
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	initial begin
		directed_row_t table_rows[$];
		grid_set_t sets[NUM_SETS];
		height_res_t res;
		height_res_t none;
		logic [POS_W-1:0] px, py;
		int pat[4][2];

		arst_n = 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		in_valid <= 1'b0;
		operation <= OP_WRITE;
		cell_index <= '0;
		height_sample <= '0;
		pos_x <= '0;
		pos_y <= '0;
		out_ready <= 1'b0;
		fail_count = 0;
		mismatch_count = 0;
		query_count = 0;
		write_count = 0;
		outside_count = 0;
		idle_in_pct = 0;
		stall_out_pct = 0;
		hold_requests = 0;
		hold_served = 0;
		hold_left = 0;
		quiet_cycles = 0;
		filled_to = 0;
		none.height = '0;
		none.off_grid = 1'b0;
		grid_cols = 7'd2;
		grid_rows = 7'd2;
		grid_stride = 31'd65536;
		grid_start_x = '0;
		grid_start_y = '0;
		repeat (10) @(posedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// make sure no query of the reset grid reads an unwritten entry
		fill_grid();

		// directed part on the reset grid: one unit cell, corners at 0..3
		table_rows = '{
			'{OP_WRITE, 12'd0, 16'sh7fff, 32'h0, 32'h0, 1'b0, 24'sd0, 1'b0},
			'{OP_WRITE, 12'd1, 16'sh8000, 32'h0, 32'h0, 1'b0, 24'sd0, 1'b0},
			'{OP_WRITE, 12'd2, 16'sh0000, 32'h0, 32'h0, 1'b0, 24'sd0, 1'b0},
			'{OP_WRITE, 12'd3, 16'sh0001, 32'h0, 32'h0, 1'b0, 24'sd0, 1'b0},
			'{OP_QUERY, 12'd0, 16'sh0, 32'h0, 32'h0, 1'b1, 24'sd8388352, 1'b0},
			'{OP_QUERY, 12'd0, 16'sh0, 32'h10000, 32'h0, 1'b1, -24'sd8388608, 1'b0},
			'{OP_QUERY, 12'd0, 16'sh0, 32'h0, 32'h10000, 1'b1, 24'sd0, 1'b0},
			'{OP_QUERY, 12'd0, 16'sh0, 32'h10000, 32'h10000, 1'b1, 24'sd256, 1'b0},
			'{OP_QUERY, 12'd0, 16'sh0, 32'hffffffff, 32'h0, 1'b1, 24'sd0, 1'b1},
			'{OP_QUERY, 12'd0, 16'sh0, 32'h0, 32'hffffffff, 1'b1, 24'sd0, 1'b1},
			'{OP_QUERY, 12'd0, 16'sh0, 32'h10001, 32'h0, 1'b1, 24'sd0, 1'b1},
			'{OP_QUERY, 12'd0, 16'sh0, 32'h0, 32'h10001, 1'b1, 24'sd0, 1'b1},
			'{OP_QUERY, 12'd0, 16'sh0, 32'h80000000, 32'h80000000, 1'b1, 24'sd0, 1'b1},
			'{OP_QUERY, 12'd0, 16'sh0, 32'h7fffffff, 32'h7fffffff, 1'b1, 24'sd0, 1'b1},
			'{OP_QUERY, 12'd0, 16'sh0, 32'h8000, 32'h8000, 1'b0, 24'sd0, 1'b0},
			'{OP_QUERY, 12'd0, 16'sh0, 32'h8001, 32'h8000, 1'b0, 24'sd0, 1'b0},
			'{OP_QUERY, 12'd0, 16'sh0, 32'h5555, 32'hffff, 1'b0, 24'sd0, 1'b0},
			'{OP_WRITE, 12'hfff, 16'sh1234, 32'h0, 32'h0, 1'b0, 24'sd0, 1'b0},
			'{OP_QUERY, 12'd0, 16'sh0, 32'hc000, 32'h4000, 1'b0, 24'sd0, 1'b0}
		};
		foreach (table_rows[i]) begin
			res.height = table_rows[i].height;
			res.off_grid = table_rows[i].off_grid;
			send_item(table_rows[i].op, table_rows[i].idx, table_rows[i].sample,
				table_rows[i].px, table_rows[i].py, table_rows[i].typed, res);
		end
		drain_pipe();

		// grid settings: reset values, extremes, out-of-range sizes, zero stride
		sets[0] = '{32'd2, 32'd2, 32'd65536, 32'h0, 32'h0};
		sets[1] = '{32'd64, 32'd2, 32'd1, 32'h80000000, 32'h80000000};
		sets[2] = '{32'hffffff80, 32'd127, 32'hffffffff, 32'h7fffffff, 32'hc0000000};
		sets[3] = '{32'd8, 32'd5, 32'h00018000, 32'hfff00000, 32'h00100000};
		sets[4] = '{32'd1, 32'd64, 32'h80000000, 32'h00000005, 32'hfffffffb};
		for (int s = 5; s < NUM_SETS; s++)
			sets[s] = '{$urandom_range(2, 12), $urandom_range(2, 12),
				$urandom_range(1, 32'h40000), $urandom_range(0, 32'h40000) - 32'h20000,
				$urandom_range(0, 32'h40000) - 32'h20000};
		pat = '{'{0, 0}, '{53, 0}, '{0, 53}, '{33, 33}};

		for (int s = 0; s < NUM_SETS; s++) begin
			write_reg(REG_GRID_COLUMNS, sets[s].cols);
			write_reg(REG_GRID_ROWS, sets[s].rows);
			write_reg(REG_STRIDE, sets[s].stride);
			write_reg(REG_START_X, sets[s].sx);
			write_reg(REG_START_Y, sets[s].sy);
			// unused register indexes leave everything as it is
			if (s == 3) begin
				write_reg(CFG_IDX_W'(5), $urandom);
				write_reg(CFG_IDX_W'(6), $urandom);
				write_reg(CFG_IDX_W'(7), $urandom);
			end
			fill_grid();
			idle_in_pct = pat[s % 4][0];
			stall_out_pct = pat[s % 4][1];
			if (s == 1)
				hold_requests++;
			for (int i = 0; i < ITEMS_PER_SET; i++) begin
				if ($urandom_range(99) < 35) begin
					send_item(OP_WRITE, IDX_W'($urandom), SAMPLE_W'($urandom), $urandom,
						$urandom, 1'b0, none);
				end else begin
					pick_position(px, py);
					send_item(OP_QUERY, IDX_W'($urandom), SAMPLE_W'($urandom), px, py,
						1'b0, none);
				end
			end
			drain_pipe();
		end

		$display("covered %0d queries (%0d off the grid) and %0d sample writes",
			query_count, outside_count, write_count);
		$display("over %0d grid settings with four handshake pacing patterns",
			NUM_SETS + 1);
		if (fail_count == 0 && pending_heights.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("%0d failures", fail_count);
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

FILE: sim.f
+incdir+src
src/hhq_pkg.sv
src/hhq_ram.sv
src/hhq_front.sv
src/hhq_fifo.sv
src/hhq_back.sv
src/heightmap_height_query_core.sv
tb/sv/heightmap_height_query_core_test.sv
